// ===== hdl/spp_pkg.sv =====
// Shared types and constants for the stream pattern patcher.
// Used by the window cell, the output buffer and the top level.
`timescale 1ns / 1ps

package spp_pkg;

  // Field widths of the configuration port and of the window state.
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned TAG_W       = 5;
  localparam int unsigned PATCH_BYTES = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_LOW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_LENGTH   = 3'd5;

  // One result item on its way to the output.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       was_replaced;
    logic       out_last;
  } out_item_t;

  // Controls broadcast from the sequencer to every window cell.
  typedef struct packed {
    logic             emit;     // oldest byte leaves, the chain shifts down
    logic             match;    // pattern found at the oldest slot
    logic [7:0]       in_byte;  // byte being written into the window
    logic [TAG_W-1:0] tag_new;  // patch tag carried by the arriving byte
    logic [LEN_W-1:0] plen;     // patch length in use
  } cell_ctrl_t;

endpackage

// ===== hdl/spp_if.sv =====
// Stream channel interfaces of the stream pattern patcher.
// Depends on spp_pkg for nothing but keeps the same widths as the package types.
`timescale 1ns / 1ps

// Input byte stream channel.
interface spp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// Patched byte stream channel.
interface spp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       was_replaced;
  logic       out_last;

  modport source (output valid, output out_byte, output was_replaced, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input was_replaced, input out_last,
                  output ready);
endinterface

// ===== hdl/spp_cell.sv =====
// One slot of the search window: a held byte and its patch tag.
// Depends on spp_pkg for the broadcast control struct and the tag width.
`timescale 1ns / 1ps

module spp_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                      clk,
  input  spp_pkg::cell_ctrl_t       ctrl,
  input  logic                      load,
  input  logic [7:0]                pattern_byte,
  input  logic [7:0]                up_byte,
  input  logic [spp_pkg::TAG_W-1:0] up_tag,
  output logic [7:0]                eff_byte,
  output logic [spp_pkg::TAG_W-1:0] eff_tag,
  output logic                      hit
);
  import spp_pkg::*;

  // A match tags this slot with patch byte INDEX, stored as INDEX + 1.
  localparam logic [TAG_W-1:0] SLOT_TAG = TAG_W'(INDEX + 1);

  logic [7:0]       held_byte;
  logic [TAG_W-1:0] held_tag;
  logic [TAG_W-1:0] pre_tag;

  // The arriving byte lands here when this is the first free slot.
  assign eff_byte = load ? ctrl.in_byte : held_byte;
  assign pre_tag  = load ? ctrl.tag_new : held_tag;

  // A new match overrides any older tag inside its patch span.
  assign eff_tag = (ctrl.match && (SLOT_TAG <= ctrl.plen)) ? SLOT_TAG : pre_tag;

  // Compare against the original byte, never the patched one.
  assign hit = (eff_byte == pattern_byte);

  // Take the upper neighbor's slot when the oldest byte leaves.
  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      held_byte <= up_byte;
      held_tag  <= up_tag;
    end else begin
      held_byte <= eff_byte;
      held_tag  <= pre_tag == eff_tag ? pre_tag : eff_tag;
    end
  end

endmodule

// ===== hdl/spp_out_buffer.sv =====
// Two-entry output buffer that decouples the window from the output channel.
// Depends on spp_pkg for the result item type and on spp_out_if.
`timescale 1ns / 1ps

module spp_out_buffer (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  spp_pkg::out_item_t push_item,
  output logic               full,
  spp_out_if.source          out
);
  import spp_pkg::*;

  out_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;

  assign pop  = out.valid && out.ready;
  assign full = (count == 2'd2);

  assign count_next = count + {1'b0, push} - {1'b0, pop};

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // The head entry drives the output channel.
  assign out.valid        = (count != 2'd0);
  assign out.out_byte     = slots[rd_ptr].out_byte;
  assign out.was_replaced = slots[rd_ptr].was_replaced;
  assign out.out_last     = slots[rd_ptr].out_last;

endmodule

// ===== hdl/stream_pattern_patcher.sv =====
// Top level of the stream pattern patcher: configuration, sequencing and the cell chain.
// Depends on spp_pkg, spp_if, spp_cell and spp_out_buffer.
//
//   channel          dir  transfer when          payload
//   byte_stream      in   valid && ready         data_byte, end_of_stream
//   patched_stream   out  valid && ready         out_byte, was_replaced, out_last
//   config write     in   write_enable           reg_index, write_data
//
// One byte is taken per cycle while the input is not held; a transfer that fills the window
// pushes the oldest byte into the two-entry output buffer at the same edge, and the buffer
// offers it from the next cycle. An end-of-stream byte holds the input while the flush drains
// the further bytes (up to MAX_PATTERN_BYTES - 1), and so does a window left fuller than a
// newly shortened pattern. Reset is synchronous and resets the configuration registers,
// the sequencer and the buffer; the window cells are not cleared, since every slot is written
// before it is read. A stalled output holds the input once both buffer entries are in use.
`timescale 1ns / 1ps

module stream_pattern_patcher #(
  parameter int unsigned MAX_PATTERN_BYTES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  spp_in_if.sink                         byte_stream,
  spp_out_if.source                      patched_stream,
  input  logic                           write_enable,
  input  logic [spp_pkg::CFG_IDX_W-1:0]  reg_index,
  input  logic [spp_pkg::CFG_DATA_W-1:0] write_data
);
  import spp_pkg::*;

  localparam int unsigned FW = $clog2(MAX_PATTERN_BYTES + 1);

  // Configuration registers.
  logic [63:0]      pattern_low;
  logic [63:0]      pattern_high;
  logic [63:0]      patch_low;
  logic [63:0]      patch_high;
  logic [LEN_W-1:0] pattern_length;
  logic [LEN_W-1:0] patch_length;

  // Sequencer state.
  logic [FW-1:0]    fill;
  logic [FW-1:0]    fill_next;
  logic [LEN_W-1:0] pending;
  logic [LEN_W-1:0] pending_next;
  logic [FW-1:0]    blocked;
  logic [FW-1:0]    blocked_next;
  logic             busy;
  logic             busy_next;
  logic             eos_hold;
  logic             eos_hold_next;

  logic [LEN_W-1:0] len_clamp;
  logic [FW-1:0]    len_eff;
  logic [LEN_W-1:0] plen;
  logic             accept;
  logic             buf_full;
  logic [FW-1:0]    fill_p;
  logic             emit;
  logic             eos_cur;
  logic             match;
  logic             emit_last;
  logic             pattern_hit;
  logic [LEN_W-1:0] pend_p;
  logic [TAG_W-1:0] tag_new;
  logic [127:0]     pattern_all;
  logic [127:0]     patch_all;
  logic [3:0]       patch_idx;
  cell_ctrl_t       ctrl;
  out_item_t        item;

  logic [7:0]       eff_byte [MAX_PATTERN_BYTES];
  logic [TAG_W-1:0] eff_tag  [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] hit;
  logic [MAX_PATTERN_BYTES-1:0] need;
  logic [MAX_PATTERN_BYTES-1:0] load;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      patch_low      <= '0;
      patch_high     <= '0;
      pattern_length <= LEN_W'(1);
      patch_length   <= '0;
    end else if (write_enable) begin
      unique case (reg_index)
        CFG_PATTERN_LOW:    pattern_low    <= write_data;
        CFG_PATTERN_HIGH:   pattern_high   <= write_data;
        CFG_PATCH_LOW:      patch_low      <= write_data;
        CFG_PATCH_HIGH:     patch_high     <= write_data;
        CFG_PATTERN_LENGTH: pattern_length <= write_data[LEN_W-1:0];
        CFG_PATCH_LENGTH:   patch_length   <= write_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pattern_all = {pattern_high, pattern_low};
  assign patch_all   = {patch_high, patch_low};

  // Lengths in use: the pattern length is held to 1..MAX, the patch length to 0..16.
  always_comb begin
    if (pattern_length == '0) begin
      len_clamp = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN_BYTES)) begin
      len_clamp = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len_clamp = pattern_length;
    end
    if (patch_length > LEN_W'(PATCH_BYTES)) begin
      plen = LEN_W'(PATCH_BYTES);
    end else begin
      plen = patch_length;
    end
  end

  assign len_eff = FW'(len_clamp);

  // Input transfers only when no step is still draining and the buffer has room.
  assign byte_stream.ready = !busy && !buf_full;
  assign accept            = byte_stream.valid && byte_stream.ready;
  assign fill_p            = accept ? FW'(fill + FW'(1)) : fill;

  // An arriving byte continues a pending patch tail.
  always_comb begin
    pend_p  = pending;
    tag_new = '0;
    if (accept && (pending != '0)) begin
      if (pending < plen) begin
        tag_new = TAG_W'(pending + LEN_W'(1));
        pend_p  = (LEN_W'(pending + LEN_W'(1)) >= plen) ? '0 : LEN_W'(pending + LEN_W'(1));
      end else begin
        pend_p = '0;
      end
    end
  end

  // Each cycle transfers a byte in (and maybe one out), drains one held byte, or does neither.
  always_comb begin
    if (accept) begin
      emit    = (fill_p >= len_eff) || byte_stream.end_of_stream;
      eos_cur = byte_stream.end_of_stream;
    end else begin
      emit    = busy && !buf_full;
      eos_cur = eos_hold;
    end
  end

  // Pattern compare over the slots the current length uses.
  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_need
    assign need[k] = FW'(k) < len_eff;
    assign load[k] = accept && (fill == FW'(k));
  end

  assign pattern_hit = &(hit | ~need);
  assign match       = emit && (fill_p >= len_eff) && (blocked == '0) && pattern_hit;
  assign emit_last   = emit && eos_cur && (fill_p == FW'(1));

  // Controls for the cell chain.
  assign ctrl.emit    = emit;
  assign ctrl.match   = match;
  assign ctrl.in_byte = byte_stream.data_byte;
  assign ctrl.tag_new = tag_new;
  assign ctrl.plen    = plen;

  // Window cells, oldest byte in cell 0.
  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
    logic [7:0]       up_byte;
    logic [TAG_W-1:0] up_tag;

    if (i == MAX_PATTERN_BYTES - 1) begin : g_top
      assign up_byte = '0;
      assign up_tag  = '0;
    end else begin : g_mid
      assign up_byte = eff_byte[i+1];
      assign up_tag  = eff_tag[i+1];
    end

    spp_cell #(
      .INDEX(i)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .load         (load[i]),
      .pattern_byte (pattern_all[8*i +: 8]),
      .up_byte      (up_byte),
      .up_tag       (up_tag),
      .eff_byte     (eff_byte[i]),
      .eff_tag      (eff_tag[i]),
      .hit          (hit[i])
    );
  end

  // The leaving byte takes its patch byte from the registers as it goes.
  assign patch_idx         = 4'(eff_tag[0] - TAG_W'(1));
  assign item.was_replaced = (eff_tag[0] != '0);
  assign item.out_byte     = item.was_replaced ? patch_all[{patch_idx, 3'b000} +: 8]
                                               : eff_byte[0];
  assign item.out_last     = emit_last;

  // Next sequencer state.
  always_comb begin
    fill_next = emit ? FW'(fill_p - FW'(1)) : fill_p;

    if (match) begin
      pending_next = (plen > LEN_W'(fill_p)) ? LEN_W'(fill_p) : '0;
      blocked_next = FW'(len_eff - FW'(1));
    end else begin
      pending_next = pend_p;
      blocked_next = (emit && (blocked != '0)) ? FW'(blocked - FW'(1)) : blocked;
    end

    if (emit) begin
      busy_next     = !emit_last && ((fill_next >= len_eff) || eos_cur);
      eos_hold_next = eos_cur && !emit_last;
    end else begin
      busy_next     = busy;
      eos_hold_next = eos_hold;
    end

    // The final byte of a stream returns the search state to its reset value.
    if (emit_last) begin
      pending_next = '0;
      blocked_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      pending  <= '0;
      blocked  <= '0;
      busy     <= 1'b0;
      eos_hold <= 1'b0;
    end else begin
      fill     <= fill_next;
      pending  <= pending_next;
      blocked  <= blocked_next;
      busy     <= busy_next;
      eos_hold <= eos_hold_next;
    end
  end

  // Output buffer.
  spp_out_buffer u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_item (item),
    .full      (buf_full),
    .out       (patched_stream)
  );

  // A byte never leaves the window into a full buffer.
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> !buf_full)
    else $error("window emitted while the output buffer was full");

  // The last byte of a stream leaves the sequencer empty and idle.
  a_stream_close: assert property (@(posedge clk) disable iff (rst)
    emit_last |=> (fill == '0) && (pending == '0) && (blocked == '0) && !busy)
    else $error("search state not cleared after end of stream");

  // A match blocks the start positions that lie inside it.
  a_match_block: assert property (@(posedge clk) disable iff (rst)
    match && !emit_last |=> blocked == FW'($past(len_eff) - FW'(1)))
    else $error("match did not block the following start positions");

endmodule

// ===== tb/spp_patch_scoreboard.sv =====
// Scoreboard for the stream pattern patcher test: a byte-exact predictor of the
// patched stream and the queue of bytes it still expects. Depends on spp_pkg.
`timescale 1ns / 1ps

package spp_patch_scoreboard_pkg;
  import spp_pkg::*;

  class patch_scoreboard;
    // Copy of the configuration registers.
    logic [63:0] pattern_lo, pattern_hi, patch_lo, patch_hi;
    logic [4:0]  pattern_len_reg, patch_len_reg;

    // Search window, oldest byte in slot 0. A tag of k+1 means patch byte k.
    logic [7:0]  window [16];
    int unsigned tags [16];
    int unsigned held;
    int unsigned blocked;
    int unsigned tail_next;

    out_item_t   expected_bytes [$];
    int unsigned errors, checked, replaced, stream_ends;

    function new();
      pattern_lo = '0;
      pattern_hi = '0;
      patch_lo = '0;
      patch_hi = '0;
      pattern_len_reg = 5'd1;
      patch_len_reg = 5'd0;
      errors = 0;
      checked = 0;
      replaced = 0;
      stream_ends = 0;
      clear_window();
    endfunction

    function void clear_window();
      for (int unsigned i = 0; i < 16; i++) begin
        window[i] = 8'h00;
        tags[i] = 0;
      end
      held = 0;
      blocked = 0;
      tail_next = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_PATTERN_LOW:    pattern_lo = value;
        CFG_PATTERN_HIGH:   pattern_hi = value;
        CFG_PATCH_LOW:      patch_lo = value;
        CFG_PATCH_HIGH:     patch_hi = value;
        CFG_PATTERN_LENGTH: pattern_len_reg = value[4:0];
        CFG_PATCH_LENGTH:   patch_len_reg = value[4:0];
        default: ;
      endcase
    endfunction

    // Pattern length in use: zero acts as one, anything above 16 as 16.
    function int unsigned search_len();
      int unsigned l;
      l = pattern_len_reg;
      if (l == 0) l = 1;
      if (l > 16) l = 16;
      return l;
    endfunction

    function int unsigned patch_count();
      return (patch_len_reg > 16) ? 16 : patch_len_reg;
    endfunction

    function logic [7:0] patch_byte(int unsigned k);
      logic [127:0] patch_all;
      patch_all = {patch_hi, patch_lo};
      return patch_all[8*(k % 16) +: 8];
    endfunction

    function logic [7:0] pattern_byte(int unsigned k);
      logic [127:0] pattern_all;
      pattern_all = {pattern_hi, pattern_lo};
      return pattern_all[8*(k % 16) +: 8];
    endfunction

    function bit pattern_at_head(int unsigned len);
      for (int unsigned k = 0; k < len && k < 16; k++)
        if (window[k] != pattern_byte(k)) return 1'b0;
      return 1'b1;
    endfunction

    // The oldest byte leaves the window; patch bytes are looked up as it leaves.
    function void release_head(bit last);
      out_item_t   item;
      int unsigned t;
      t = tags[0];
      item.out_byte = (t != 0) ? patch_byte(t - 1) : window[0];
      item.was_replaced = (t != 0);
      item.out_last = last;
      expected_bytes.push_back(item);
      for (int unsigned i = 1; i < held && i < 16; i++) begin
        window[i-1] = window[i];
        tags[i-1] = tags[i];
      end
      if (held > 0) held--;
      if (held < 16) begin
        window[held] = 8'h00;
        tags[held] = 0;
      end
      if (blocked > 0) blocked--;
    endfunction

    // Notes one accepted input transfer and predicts the bytes it releases.
    function void note_byte(logic [7:0] b, logic eos);
      int unsigned plen, n, len;
      plen = patch_count();
      n = 0;
      while (held >= 16 && n < 16) begin
        release_head(1'b0);
        n++;
      end

      // Place the new byte, carrying on the tail of a patch still being written.
      window[held] = b;
      tags[held] = 0;
      if (tail_next != 0) begin
        if (tail_next < plen) begin
          tags[held] = tail_next + 1;
          tail_next++;
          if (tail_next >= plen) tail_next = 0;
        end else begin
          tail_next = 0;
        end
      end
      held++;

      // Test the head of the window against the pattern and let bytes leave.
      while (held >= search_len() && n < 16) begin
        len = search_len();
        if (blocked == 0 && pattern_at_head(len)) begin
          for (int unsigned k = 0; k < plen && k < held && k < 16; k++) tags[k] = k + 1;
          tail_next = (plen > held) ? held : 0;
          blocked = len;
        end
        release_head(eos && held == 1);
        n++;
      end

      // End of stream flushes whatever is still held.
      if (eos) begin
        while (held > 0 && n < 16) begin
          release_head(held == 1);
          n++;
        end
        clear_window();
        stream_ends++;
      end
    endfunction

    // Compares one output transfer with the oldest expected byte.
    function void check_byte(out_item_t got);
      out_item_t want;
      checked++;
      if (got.was_replaced === 1'b1) replaced++;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected output: expected nothing, actual byte %h replaced %b last %b",
                 $time, got.out_byte, got.was_replaced, got.out_last);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte mismatch: expected %h actual %h",
                 $time, want.out_byte, got.out_byte);
      end
      if (got.was_replaced !== want.was_replaced) begin
        errors++;
        $display("%0t: was_replaced mismatch: expected %b actual %b",
                 $time, want.was_replaced, got.was_replaced);
      end
      if (got.out_last !== want.out_last) begin
        errors++;
        $display("%0t: out_last mismatch: expected %b actual %b",
                 $time, want.out_last, got.out_last);
      end
    endfunction
  endclass

endpackage

// ===== tb/stream_pattern_patcher_test.sv =====
// Self-checking test of stream_pattern_patcher: directed streams, then random phases
// with varied configuration and flow control. Depends on spp_pkg, spp_if and the scoreboard.
`timescale 1ns / 1ps

module stream_pattern_patcher_test;
  import spp_pkg::*;
  import spp_patch_scoreboard_pkg::*;

  localparam int unsigned PRESSURE_PHASE = 4;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned PHASE_ITEMS    = 50;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  write_enable;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] write_data;

  spp_in_if  byte_stream ();
  spp_out_if patched_stream ();

  patch_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned phase_no       = 0;
  int unsigned bytes_sent     = 0;

  stream_pattern_patcher uut (
    .clk            (clk),
    .rst            (rst),
    .byte_stream    (byte_stream),
    .patched_stream (patched_stream),
    .write_enable   (write_enable),
    .reg_index      (reg_index),
    .write_data     (write_data)
  );

  always #2 clk = ~clk;

  // Offers one byte, with random idle cycles first, and waits for its transfer.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_stream.valid <= 1'b0;
      @(posedge clk);
    end
    byte_stream.valid <= 1'b1;
    byte_stream.data_byte <= b;
    byte_stream.end_of_stream <= eos;
    do @(posedge clk); while (byte_stream.ready !== 1'b1);
    sb.note_byte(b, eos);
    bytes_sent++;
  endtask

  // Stops offering and waits until every expected byte is out and the block is quiet.
  task automatic settle();
    byte_stream.valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic configure(input logic [63:0] pat_lo, input logic [63:0] pat_hi,
                           input logic [63:0] rep_lo, input logic [63:0] rep_hi,
                           input logic [4:0] pat_len, input logic [4:0] rep_len);
    write_reg(CFG_PATTERN_LOW, pat_lo);
    write_reg(CFG_PATTERN_HIGH, pat_hi);
    write_reg(CFG_PATCH_LOW, rep_lo);
    write_reg(CFG_PATCH_HIGH, rep_hi);
    write_reg(CFG_PATTERN_LENGTH, {59'd0, pat_len});
    write_reg(CFG_PATCH_LENGTH, {59'd0, rep_len});
    write_enable <= 1'b0;
  endtask

  // Random stream built mostly from whole pattern copies, with broken copies,
  // pattern-alphabet bytes and plain noise mixed in.
  task automatic run_random_stream(input int unsigned count);
    logic [7:0]   stream_q [$];
    logic [127:0] pat;
    int unsigned  len, cut, r;
    logic         eos;
    len = sb.search_len();
    pat = {sb.pattern_hi, sb.pattern_lo};
    while (stream_q.size() < count) begin
      r = $urandom_range(99);
      if (r < 45) begin
        for (int unsigned k = 0; k < len; k++) stream_q.push_back(pat[8*k +: 8]);
      end else if (r < 65) begin
        cut = $urandom_range(len - 1);
        for (int unsigned k = 0; k < cut; k++) stream_q.push_back(pat[8*k +: 8]);
        stream_q.push_back(8'($urandom_range(255)));
      end else if (r < 80) begin
        stream_q.push_back(pat[8*$urandom_range(len - 1) +: 8]);
      end else begin
        stream_q.push_back(8'($urandom_range(255)));
      end
    end
    for (int unsigned i = 0; i < count; i++) begin
      eos = ($urandom_range(29) == 0) || (i == count - 1 && $urandom_range(1) == 1);
      send_byte(stream_q[i], eos);
    end
  endtask

  // Timeout guard.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Output side: checks each transfer and drives ready, with one long hold-off.
  initial begin
    out_item_t   got;
    int unsigned hold_count;
    bit          hold_done;
    hold_count = 0;
    hold_done = 1'b0;
    patched_stream.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && patched_stream.valid === 1'b1 && patched_stream.ready === 1'b1) begin
        got.out_byte = patched_stream.out_byte;
        got.was_replaced = patched_stream.was_replaced;
        got.out_last = patched_stream.out_last;
        sb.check_byte(got);
      end
      if (phase_no == PRESSURE_PHASE && !hold_done) begin
        hold_count = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_count > 0) begin
        hold_count--;
        patched_stream.ready <= 1'b0;
      end else begin
        patched_stream.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Main sequence: reset, directed streams, then the random phases.
  initial begin
    logic [4:0] pat_len, rep_len;
    rst <= 1'b1;
    write_enable <= 1'b0;
    reg_index <= CFG_PATTERN_LOW;
    write_data <= '0;
    byte_stream.valid <= 1'b0;
    byte_stream.data_byte <= 8'h00;
    byte_stream.end_of_stream <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: a one-byte zero pattern that matches but patches nothing.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    settle();

    // Three-byte pattern, five-byte patch: a false start, back-to-back matches where
    // the later patch wins, and a match at the end whose patch runs past it.
    configure(64'h0000_0000_0033_2211, 64'h0, 64'hA7A6_A5A4_A3A2_A1A0,
              64'hAFAE_ADAC_ABAA_A9A8, 5'd3, 5'd5);
    send_byte(8'h11, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b1);
    // A match that would need bytes past the end does not count.
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    // Bytes held while the pattern is shortened drain after the next transfer.
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    settle();
    configure(64'h0000_0000_0033_2211, 64'h0, 64'hA7A6_A5A4_A3A2_A1A0,
              64'hAFAE_ADAC_ABAA_A9A8, 5'd1, 5'd5);
    send_byte(8'h11, 1'b0);
    send_byte(8'h00, 1'b1);
    settle();

    // Random phases, each with its own lengths and flow control.
    for (int unsigned p = 0; p < 6; p++) begin
      case (p)
        0: begin pat_len = 5'($urandom_range(4, 1));  rep_len = 5'($urandom_range(6)); end
        1: begin pat_len = 5'd16;                     rep_len = 5'd16; end
        2: begin pat_len = 5'd0;                      rep_len = 5'd20; end
        3: begin pat_len = 5'd20;                     rep_len = 5'd0; end
        4: begin pat_len = 5'd5;                      rep_len = 5'd9; end
        default: begin pat_len = 5'($urandom_range(16, 1)); rep_len = 5'($urandom_range(16)); end
      endcase
      configure({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, pat_len, rep_len);
      case (p)
        1: begin send_idle_pct = 56; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        3, 5: begin send_idle_pct = 14; recv_stall_pct = 14; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      phase_no = p;
      run_random_stream(PHASE_ITEMS);
      settle();
    end

    $display("Sent %0d bytes in %0d finished streams; checked %0d output bytes, %0d from the patch.",
             bytes_sent, sb.stream_ends, sb.checked, sb.replaced);
    $display("Covered pattern lengths 0 to 20, patch lengths 0 to 20, idle and stall phases.");
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
